// ===== src/ahlrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahlrc_pkg
// Shared types and constants for the ATT handle list response checker:
// transaction payloads, parse phases, request kinds and register indexes.
// ----------------------------------------------------------------------------
package ahlrc_pkg;

  // input transaction: one response byte
  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       last_byte;
  } in_t;

  // result transaction, given on the last byte of a response
  typedef struct packed {
    logic        status;
    logic        procedure_done;
    logic [15:0] next_start;
  } out_t;

  // parse phase of the response walker
  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_FORMAT = 3'd1,
    PH_H1LO   = 3'd2,
    PH_H1HI   = 3'd3,
    PH_H2LO   = 3'd4,
    PH_H2HI   = 3'd5,
    PH_VALUE  = 3'd6
  } phase_t;

  // request kinds (code 3 is treated as group type)
  localparam logic [1:0] KIND_FIND  = 2'd0;
  localparam logic [1:0] KIND_TYPE  = 2'd1;
  localparam logic [1:0] KIND_GROUP = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_REQUEST_KIND = 2'd0;
  localparam logic [1:0] REG_RANGE_START  = 2'd1;
  localparam logic [1:0] REG_RANGE_END    = 2'd2;
  localparam logic [1:0] REG_CONTINUING   = 2'd3;

  // entry layout constants
  localparam logic [7:0]  FMT_UUID16       = 8'd1;
  localparam logic [7:0]  UUID16_LEN       = 8'd2;
  localparam logic [7:0]  UUID128_LEN      = 8'd16;
  localparam logic [7:0]  TYPE_PREFIX_LEN  = 8'd2;
  localparam logic [7:0]  GROUP_PREFIX_LEN = 8'd4;

  // register reset values
  localparam logic [15:0] RANGE_START_RST = 16'h0001;
  localparam logic [15:0] RANGE_END_RST   = 16'hFFFF;

endpackage

// ===== src/ahlrc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahlrc_parser
// Walks the response one byte per step, checks handle order and range, and
// forms the result on the last byte of the response.
// ----------------------------------------------------------------------------
module ahlrc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ahlrc_pkg::in_t    in_data,
  input  logic [1:0]        request_kind,
  input  logic [15:0]       range_start,
  input  logic [15:0]       range_end,
  input  logic              continuing,
  output logic              res_valid,
  output ahlrc_pkg::out_t   res_data
);

  ahlrc_pkg::phase_t phase_r, phase_nxt, phase_w;
  logic [15:0] exp_r, exp_nxt, exp_w;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [7:0]  vlen_r, vlen_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        err_r, err_nxt, err_w;

  logic        group;
  logic [7:0]  prefix;
  logic [15:0] hnd;
  logic        hnd_bad;
  logic        err_fin;
  logic        done;

  // handle assembled from latched low byte and current high byte
  assign group   = (request_kind >= ahlrc_pkg::KIND_GROUP);
  assign prefix  = (request_kind == ahlrc_pkg::KIND_TYPE) ? ahlrc_pkg::TYPE_PREFIX_LEN
                                                          : ahlrc_pkg::GROUP_PREFIX_LEN;
  assign hnd     = {in_data.pdu_byte, lo_r};
  assign hnd_bad = (hnd == 16'd0) || (exp_r == 16'd0) || (hnd < exp_r) || (hnd > range_end);

  // next state: byte walk, then end-of-response override
  always_comb begin
    phase_w  = phase_r;
    exp_w    = exp_r;
    lo_nxt   = lo_r;
    prev_nxt = prev_r;
    vlen_nxt = vlen_r;
    left_nxt = left_r;
    err_w    = err_r;
    case (phase_r)
      ahlrc_pkg::PH_FORMAT: begin
        if (request_kind == ahlrc_pkg::KIND_FIND) begin
          vlen_nxt = (in_data.pdu_byte == ahlrc_pkg::FMT_UUID16) ? ahlrc_pkg::UUID16_LEN
                                                                 : ahlrc_pkg::UUID128_LEN;
        end else if (in_data.pdu_byte < prefix) begin
          err_w    = 1'b1;
          vlen_nxt = 8'd0;
        end else begin
          vlen_nxt = in_data.pdu_byte - prefix;
        end
        phase_w = ahlrc_pkg::PH_H1LO;
      end
      ahlrc_pkg::PH_H1LO: begin
        lo_nxt  = in_data.pdu_byte;
        phase_w = ahlrc_pkg::PH_H1HI;
      end
      ahlrc_pkg::PH_H1HI: begin
        if (hnd_bad) err_w = 1'b1;
        if (group) begin
          prev_nxt = hnd;
          phase_w  = ahlrc_pkg::PH_H2LO;
        end else begin
          // wrap of 0xffff gives zero, which blocks any further entry
          exp_w = hnd + 16'd1;
          if (vlen_r == 8'd0) begin
            phase_w = ahlrc_pkg::PH_H1LO;
          end else begin
            left_nxt = vlen_r;
            phase_w  = ahlrc_pkg::PH_VALUE;
          end
        end
      end
      ahlrc_pkg::PH_H2LO: begin
        lo_nxt  = in_data.pdu_byte;
        phase_w = ahlrc_pkg::PH_H2HI;
      end
      ahlrc_pkg::PH_H2HI: begin
        if (hnd_bad || (hnd < prev_r)) err_w = 1'b1;
        exp_w = hnd + 16'd1;
        if (vlen_r == 8'd0) begin
          phase_w = ahlrc_pkg::PH_H1LO;
        end else begin
          left_nxt = vlen_r;
          phase_w  = ahlrc_pkg::PH_VALUE;
        end
      end
      ahlrc_pkg::PH_VALUE: begin
        left_nxt = left_r - 8'd1;
        if (left_nxt == 8'd0) phase_w = ahlrc_pkg::PH_H1LO;
      end
      default: begin
        exp_w   = range_start;
        err_w   = 1'b0;
        phase_w = ahlrc_pkg::PH_FORMAT;
      end
    endcase

    if (in_data.last_byte) begin
      phase_nxt = ahlrc_pkg::PH_OPCODE;
      exp_nxt   = range_start;
      err_nxt   = 1'b0;
    end else begin
      phase_nxt = phase_w;
      exp_nxt   = exp_w;
      err_nxt   = err_w;
    end
  end

  // result: ending off an entry boundary is invalid
  always_comb begin
    err_fin   = err_w || (phase_w != ahlrc_pkg::PH_H1LO);
    done      = err_fin || !continuing || (exp_w == 16'd0) || (exp_w == range_end + 16'd1);
    res_valid = step && in_data.last_byte;
    res_data.status         = err_fin;
    res_data.procedure_done = done;
    res_data.next_start     = done ? 16'd0 : exp_w;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ahlrc_pkg::PH_OPCODE;
      exp_r   <= ahlrc_pkg::RANGE_START_RST;
      lo_r    <= 8'd0;
      prev_r  <= 16'd0;
      vlen_r  <= 8'd0;
      left_r  <= 8'd0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      lo_r    <= lo_nxt;
      prev_r  <= prev_nxt;
      vlen_r  <= vlen_nxt;
      left_r  <= left_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== src/ahlrc_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahlrc_out_buf
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module ahlrc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ahlrc_pkg::out_t   load_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ahlrc_pkg::out_t   out_data
);

  logic            vld_r, vld_nxt;
  ahlrc_pkg::out_t data_r;

  // valid: set on load, cleared when taken
  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload only changes on load
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ===== src/att_handle_list_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_handle_list_response_checker
// Validates an ATT find information / read by type / read by group type
// response fed one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_stall/in_data carry one PDU byte per transaction, opcode
//    first; in_data.last_byte marks the final byte of the response.
//  - out_valid/out_stall/out_data carry one result transaction per response
//    (status, procedure_done, next_start), none for other bytes.
//  - cfg_we/cfg_addr/cfg_wdata write request_kind, range_start, range_end and
//    continuing; write only while no response is in flight.
//  - throughput: one byte per cycle while in_stall is low; each byte is checked by the
//    parser between the input register and the result register.
//  - the parser forms the result as the last byte leaves the input register, and it is loaded into the result register.
//  - reset (rst_n low, synchronous) empties both registers, returns the parser
//    to the opcode phase and loads the register reset values.
//  - while the receiver stalls with a result pending, a byte with no result
//    still moves through; the next last byte waits in the input register and
//    in_stall rises until the pending result is taken.
// ----------------------------------------------------------------------------
module att_handle_list_response_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ahlrc_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ahlrc_pkg::out_t   out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  logic [1:0]      kind_r;
  logic [15:0]     rstart_r;
  logic [15:0]     rend_r;
  logic            cont_r;

  logic            in_vld_r, in_vld_nxt;
  ahlrc_pkg::in_t  in_r;
  logic            adv;
  logic            in_take;
  logic            res_valid;
  ahlrc_pkg::out_t res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= ahlrc_pkg::KIND_FIND;
      rstart_r <= ahlrc_pkg::RANGE_START_RST;
      rend_r   <= ahlrc_pkg::RANGE_END_RST;
      cont_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ahlrc_pkg::REG_REQUEST_KIND: kind_r   <= cfg_wdata[1:0];
        ahlrc_pkg::REG_RANGE_START:  rstart_r <= cfg_wdata;
        ahlrc_pkg::REG_RANGE_END:    rend_r   <= cfg_wdata;
        ahlrc_pkg::REG_CONTINUING:   cont_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register advances unless its result has nowhere to go
  assign adv      = in_vld_r && (!in_r.last_byte || !out_valid || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  // byte walker
  ahlrc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .in_data      (in_r),
    .request_kind (kind_r),
    .range_start  (rstart_r),
    .range_end    (rend_r),
    .continuing   (cont_r),
    .res_valid    (res_valid),
    .res_data     (res_data)
  );

  // result register
  ahlrc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/ahlrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahlrc_checker
// Port-level checks on the response checker's result channel.
// ----------------------------------------------------------------------------
module ahlrc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input ahlrc_pkg::out_t out_data
);

  // a stalled result transaction stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an invalid response always ends the procedure
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.procedure_done)
    else $error("invalid response without procedure_done");

  // next_start is zero exactly when the procedure is done
  a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.procedure_done == (out_data.next_start == 16'd0)))
    else $error("next_start inconsistent with procedure_done");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind att_handle_list_response_checker ahlrc_checker u_ahlrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ATT handle list response checker. Response PDUs
// for all request kinds are streamed in byte by byte: a few hand-built cases,
// then generated responses (mostly well formed, some truncated, corrupted or
// noise) under several register settings and idling patterns. A byte-level
// parser in the bench predicts each result, which is compared in order with
// what the block returns.
// ----------------------------------------------------------------------------
module tb;

  // response opcodes and the unused request kind
  localparam logic [7:0] OP_FIND_INFO_RSP  = 8'h05;
  localparam logic [7:0] OP_READ_TYPE_RSP  = 8'h09;
  localparam logic [7:0] OP_READ_GROUP_RSP = 8'h11;
  localparam logic [1:0] KIND_UNUSED       = 2'd3;
  localparam int         CYCLE_LIMIT       = 400000;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  ahlrc_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  ahlrc_pkg::out_t out_data;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_addr  = '0;
  logic [15:0]     cfg_wdata = '0;

  att_handle_list_response_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // register copies used by the parser model
  logic [1:0]  cfg_kind  = ahlrc_pkg::KIND_FIND;
  logic [15:0] cfg_start = ahlrc_pkg::RANGE_START_RST;
  logic [15:0] cfg_end   = ahlrc_pkg::RANGE_END_RST;
  logic        cfg_cont  = 1'b0;

  // parser model state
  ahlrc_pkg::phase_t walk_phase   = ahlrc_pkg::PH_OPCODE;
  logic [15:0]       next_handle  = ahlrc_pkg::RANGE_START_RST;
  logic [7:0]        handle_lo    = '0;
  logic [15:0]       first_handle = '0;
  logic [7:0]        value_len    = '0;
  logic [7:0]        value_left   = '0;
  logic              resp_bad     = 1'b0;

  ahlrc_pkg::out_t results_due[$];
  logic [7:0]      pdu_bytes[$];
  int              mismatches    = 0;
  int              bytes_sent    = 0;
  int              cycles        = 0;
  int              seg_count     = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_request  = 0;
  int              hold_left     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** att_handle_list_response_checker: FAILED **");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    ahlrc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result: status %0d done %0d next 0x%04h", $time,
                   out_data.status, out_data.procedure_done, out_data.next_start);
      end else begin
        want = results_due.pop_front();
        if (out_data.status !== want.status ||
            out_data.procedure_done !== want.procedure_done ||
            out_data.next_start !== want.next_start) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch: expected %0d/%0d/0x%04h, got %0d/%0d/0x%04h",
                     $time, want.status, want.procedure_done, want.next_start,
                     out_data.status, out_data.procedure_done, out_data.next_start);
        end
      end
    end
  end

  // handle check against expected next handle and range end
  function automatic logic handle_bad(logic [15:0] h);
    return h == 16'd0 || next_handle == 16'd0 || h < next_handle || h > cfg_end;
  endfunction

  // end of the handle part of an entry; handle 0xFFFF wraps to zero
  task automatic close_entry(logic [15:0] h);
    next_handle = h + 16'd1;
    if (value_len == 8'd0) begin
      walk_phase = ahlrc_pkg::PH_H1LO;
    end else begin
      value_left = value_len;
      walk_phase = ahlrc_pkg::PH_VALUE;
    end
  endtask

  // parser model: one accepted byte, queues a result on the last byte
  task automatic parse_pdu_byte(ahlrc_pkg::in_t t);
    logic [15:0]     h;
    logic [15:0]     end_plus;
    logic [7:0]      prefix;
    logic            done;
    ahlrc_pkg::out_t r;
    h = {t.pdu_byte, handle_lo};
    case (walk_phase)
      ahlrc_pkg::PH_FORMAT: begin
        if (cfg_kind == ahlrc_pkg::KIND_FIND) begin
          value_len = (t.pdu_byte == ahlrc_pkg::FMT_UUID16) ? ahlrc_pkg::UUID16_LEN
                                                             : ahlrc_pkg::UUID128_LEN;
        end else begin
          prefix = (cfg_kind == ahlrc_pkg::KIND_TYPE) ? ahlrc_pkg::TYPE_PREFIX_LEN
                                                      : ahlrc_pkg::GROUP_PREFIX_LEN;
          if (t.pdu_byte < prefix) begin
            resp_bad = 1'b1;
            value_len = 8'd0;
          end else begin
            value_len = t.pdu_byte - prefix;
          end
        end
        walk_phase = ahlrc_pkg::PH_H1LO;
      end
      ahlrc_pkg::PH_H1LO: begin
        handle_lo = t.pdu_byte;
        walk_phase = ahlrc_pkg::PH_H1HI;
      end
      ahlrc_pkg::PH_H1HI: begin
        if (handle_bad(h)) resp_bad = 1'b1;
        if (cfg_kind >= ahlrc_pkg::KIND_GROUP) begin
          first_handle = h;
          walk_phase = ahlrc_pkg::PH_H2LO;
        end else begin
          close_entry(h);
        end
      end
      ahlrc_pkg::PH_H2LO: begin
        handle_lo = t.pdu_byte;
        walk_phase = ahlrc_pkg::PH_H2HI;
      end
      ahlrc_pkg::PH_H2HI: begin
        if (handle_bad(h) || h < first_handle) resp_bad = 1'b1;
        close_entry(h);
      end
      ahlrc_pkg::PH_VALUE: begin
        value_left = value_left - 8'd1;
        if (value_left == 8'd0) walk_phase = ahlrc_pkg::PH_H1LO;
      end
      default: begin
        // opcode byte: range start sampled here
        next_handle = cfg_start;
        resp_bad = 1'b0;
        walk_phase = ahlrc_pkg::PH_FORMAT;
      end
    endcase
    if (t.last_byte) begin
      // must end on an entry boundary
      if (walk_phase != ahlrc_pkg::PH_H1LO) resp_bad = 1'b1;
      end_plus = cfg_end + 16'd1;
      done = resp_bad || !cfg_cont || next_handle == 16'd0 || next_handle == end_plus;
      r.status = resp_bad;
      r.procedure_done = done;
      r.next_start = done ? 16'd0 : next_handle;
      results_due.push_back(r);
      walk_phase = ahlrc_pkg::PH_OPCODE;
      next_handle = cfg_start;
      resp_bad = 1'b0;
    end
  endtask

  // offer one byte, with random gaps before it, until it is taken
  task automatic send_byte(logic [7:0] b, logic is_last);
    ahlrc_pkg::in_t t;
    t.pdu_byte = b;
    t.last_byte = is_last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    parse_pdu_byte(t);
    bytes_sent++;
  endtask

  task automatic send_pdu();
    foreach (pdu_bytes[i]) send_byte(pdu_bytes[i], i == pdu_bytes.size() - 1);
  endtask

  // drop valid and wait until every predicted result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers, only while the block is idle
  task automatic set_regs(logic [1:0] kind, logic [15:0] lo_h, logic [15:0] hi_h,
                          logic cont);
    cfg_we <= 1'b1;
    cfg_addr <= ahlrc_pkg::REG_REQUEST_KIND;
    cfg_wdata <= {14'd0, kind};
    @(posedge clk);
    cfg_addr <= ahlrc_pkg::REG_RANGE_START;
    cfg_wdata <= lo_h;
    @(posedge clk);
    cfg_addr <= ahlrc_pkg::REG_RANGE_END;
    cfg_wdata <= hi_h;
    @(posedge clk);
    cfg_addr <= ahlrc_pkg::REG_CONTINUING;
    cfg_wdata <= {15'd0, cont};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_kind = kind;
    cfg_start = lo_h;
    cfg_end = hi_h;
    cfg_cont = cont;
  endtask

  // random settings; the first few segments walk through fixed range shapes
  task automatic pick_settings();
    int          shape;
    logic [15:0] lo_h;
    logic [15:0] hi_h;
    shape = (seg_count < 6) ? seg_count : $urandom_range(5);
    seg_count++;
    case (shape)
      0: begin
        lo_h = ahlrc_pkg::RANGE_START_RST;
        hi_h = ahlrc_pkg::RANGE_END_RST;
      end
      1: begin
        lo_h = 16'($urandom_range(16'hFFFF, 16'hFFF0));
        hi_h = 16'hFFFF;
      end
      2: begin
        lo_h = 16'($urandom_range(16'hFF00, 1));
        hi_h = lo_h + 16'($urandom_range(40));
      end
      3: begin
        lo_h = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
        hi_h = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      end
      4: begin
        lo_h = 16'($urandom);
        hi_h = 16'($urandom);
      end
      default: begin
        lo_h = 16'($urandom_range(100, 1));
        hi_h = lo_h + 16'($urandom_range(8));
      end
    endcase
    set_regs(2'($urandom_range(3)), lo_h, hi_h, 1'($urandom_range(1)));
  endtask

  // build one response for the current settings, sometimes damaged
  task automatic build_response();
    int         cur;
    int         h1;
    int         h2;
    int         n;
    int         vlen;
    int         cut;
    logic [7:0] op;
    logic [7:0] len_byte;
    logic [7:0] prefix;
    case (cfg_kind)
      ahlrc_pkg::KIND_FIND: op = OP_FIND_INFO_RSP;
      ahlrc_pkg::KIND_TYPE: op = OP_READ_TYPE_RSP;
      default:              op = OP_READ_GROUP_RSP;
    endcase
    if ($urandom_range(9) == 0) op = 8'($urandom);
    n = $urandom_range(4);
    // format or length byte, with the value size it implies
    if (cfg_kind == ahlrc_pkg::KIND_FIND) begin
      len_byte = ($urandom_range(9) < 6) ? ahlrc_pkg::FMT_UUID16 : 8'($urandom_range(255));
      vlen = (len_byte == ahlrc_pkg::FMT_UUID16) ? ahlrc_pkg::UUID16_LEN
                                                 : ahlrc_pkg::UUID128_LEN;
    end else begin
      if ($urandom_range(19) == 0) begin
        vlen = $urandom_range(251);
        n = 1;
      end else begin
        vlen = $urandom_range(6);
      end
      prefix = (cfg_kind == ahlrc_pkg::KIND_TYPE) ? ahlrc_pkg::TYPE_PREFIX_LEN
                                                  : ahlrc_pkg::GROUP_PREFIX_LEN;
      len_byte = 8'(vlen) + prefix;
    end
    pdu_bytes.delete();
    pdu_bytes.push_back(op);
    pdu_bytes.push_back(len_byte);
    // ascending entries inside the range
    cur = cfg_start;
    for (int i = 0; i < n; i++) begin
      h1 = cur + $urandom_range(2);
      if (h1 > cfg_end || h1 > 65535) break;
      pdu_bytes.push_back(8'(h1));
      pdu_bytes.push_back(8'(h1 >> 8));
      cur = h1 + 1;
      if (cfg_kind >= ahlrc_pkg::KIND_GROUP) begin
        h2 = h1 + $urandom_range(4);
        if (h2 > cfg_end) h2 = cfg_end;
        pdu_bytes.push_back(8'(h2));
        pdu_bytes.push_back(8'(h2 >> 8));
        cur = h2 + 1;
      end
      repeat (vlen) pdu_bytes.push_back(8'($urandom));
    end
    // damage: truncation, one corrupted byte, pure noise, trailing bytes
    case ($urandom_range(9))
      0: begin
        cut = $urandom_range(pdu_bytes.size() - 1, 1);
        repeat (cut) void'(pdu_bytes.pop_back());
      end
      1: pdu_bytes[$urandom_range(pdu_bytes.size() - 1, 1)] = 8'($urandom);
      2: begin
        pdu_bytes.delete();
        repeat ($urandom_range(12, 1)) pdu_bytes.push_back(8'($urandom));
      end
      3: repeat ($urandom_range(3, 1)) pdu_bytes.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // empty payload and a response with no entries
  task automatic test_empty_and_bare();
    set_regs(ahlrc_pkg::KIND_FIND, ahlrc_pkg::RANGE_START_RST, ahlrc_pkg::RANGE_END_RST,
             1'b0);
    pdu_bytes = '{OP_FIND_INFO_RSP};
    send_pdu();
    pdu_bytes = '{OP_FIND_INFO_RSP, ahlrc_pkg::FMT_UUID16};
    send_pdu();
  endtask

  // read by type: handle extremes with wrap, short length byte, truncation
  task automatic test_read_by_type();
    wait_for_results();
    set_regs(ahlrc_pkg::KIND_TYPE, 16'h0001, 16'hFFFF, 1'b1);
    pdu_bytes = '{OP_READ_TYPE_RSP, ahlrc_pkg::TYPE_PREFIX_LEN, 8'h01, 8'h00, 8'hFF,
                  8'hFF};
    send_pdu();
    pdu_bytes = '{OP_READ_TYPE_RSP, 8'h01};
    send_pdu();
    pdu_bytes = '{OP_READ_TYPE_RSP, 8'h03, 8'h05, 8'h00};
    send_pdu();
  endtask

  // unused kind acts as group type: range end reached, then an error mid-response
  task automatic test_group_and_errors();
    wait_for_results();
    set_regs(KIND_UNUSED, 16'h0010, 16'h0020, 1'b1);
    pdu_bytes = '{OP_READ_GROUP_RSP, ahlrc_pkg::GROUP_PREFIX_LEN, 8'h10, 8'h00, 8'h20,
                  8'h00};
    send_pdu();
    pdu_bytes = '{OP_READ_GROUP_RSP, ahlrc_pkg::GROUP_PREFIX_LEN, 8'h00, 8'h00, 8'h15,
                  8'h00, 8'h16, 8'h00, 8'h18, 8'h00};
    send_pdu();
  endtask

  // generated responses in segments, new settings per segment
  task automatic test_random_traffic(int send_pct, int recv_pct, int target);
    int goal;
    int seg_end;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = bytes_sent + target;
    while (bytes_sent < goal) begin
      wait_for_results();
      pick_settings();
      seg_end = bytes_sent + 40;
      while (bytes_sent < seg_end && bytes_sent < goal) begin
        build_response();
        send_pdu();
      end
    end
  endtask

  // receiver holds off while bytes keep coming, then sender pauses to drain
  task automatic test_receiver_hold();
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(ahlrc_pkg::KIND_TYPE, ahlrc_pkg::RANGE_START_RST, ahlrc_pkg::RANGE_END_RST,
             1'b1);
    hold_request = 200;
    repeat (3) begin
      build_response();
      send_pdu();
    end
    wait_for_results();
    repeat (2) begin
      build_response();
      send_pdu();
    end
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_bare();
    test_read_by_type();
    test_group_and_errors();
    test_random_traffic(30, 54, 90);
    test_random_traffic(54, 30, 90);
    test_receiver_hold();
    test_random_traffic(0, 0, 90);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("** att_handle_list_response_checker: PASSED **");
    end else begin
      $display("** att_handle_list_response_checker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ahlrc_pkg.sv
src/ahlrc_parser.sv
src/ahlrc_out_buf.sv
src/att_handle_list_response_checker.sv
src/ahlrc_checker.sv
tb/tb.sv
